FILE: src/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Types, codes and the power-of-ten table shared by the binary to decimal
// digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

  // Magnitude of a double word: 36-bit high word over 35 low bits
  localparam int unsigned MagW      = 71;
  localparam int unsigned PowerEntries = 22;
  localparam int unsigned WidthW    = 5;   // holds 1 .. PowerEntries
  localparam int unsigned LenW      = 6;
  localparam int unsigned WordW     = 36;
  localparam int unsigned OffW      = 18;
  localparam int unsigned DigitW    = 4;   // digit 0 .. 10
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);

  localparam logic [DigitW-1:0] DigitCap = 4'd10;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_SHORT = 2'd2
  } bcd_kind_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SEARCH,
    FE_PUSH
  } bcd_fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_SHORT,
    BE_FILL,
    BE_DIGIT
  } bcd_be_state_e;

  // One classified conversion, handed from the front to the back
  typedef struct packed {
    logic [MagW-1:0]          mag;
    logic [WidthW-1:0]        width;
    logic [LenW-1:0]          fill_cnt;
    logic                     too_short;
    logic                     xlat;
    logic signed [OffW-1:0]   offset;
    logic [WordW-1:0]         fill_value;
    logic                     minus;
    logic                     nonzero;
  } bcd_cmd_t;

  // Power of ten for a field width: width k compares against 10^(k-1)
  function automatic logic [MagW-1:0] pow10(input logic [WidthW-1:0] k);
    logic [MagW-1:0] p;
    unique case (k)
      5'd1:    p = 71'd1;
      5'd2:    p = 71'd10;
      5'd3:    p = 71'd100;
      5'd4:    p = 71'd1000;
      5'd5:    p = 71'd10000;
      5'd6:    p = 71'd100000;
      5'd7:    p = 71'd1000000;
      5'd8:    p = 71'd10000000;
      5'd9:    p = 71'd100000000;
      5'd10:   p = 71'd1000000000;
      5'd11:   p = 71'd10000000000;
      5'd12:   p = 71'd100000000000;
      5'd13:   p = 71'd1000000000000;
      5'd14:   p = 71'd10000000000000;
      5'd15:   p = 71'd100000000000000;
      5'd16:   p = 71'd1000000000000000;
      5'd17:   p = 71'd10000000000000000;
      5'd18:   p = 71'd100000000000000000;
      5'd19:   p = 71'd1000000000000000000;
      5'd20:   p = 71'd10000000000000000000;
      5'd21:   p = 71'd100000000000000000000;
      5'd22:   p = 71'd1000000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: src/bcd_in_if.sv
// ----------------------------------------------------------------------------
// bcd_in_if
// Request channel: one double-word integer with its formatting controls.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] high_word;
  logic [35:0]        low_word;
  logic [5:0]         dest_length;
  logic               left_fill;
  logic               translate_mode;
  logic signed [17:0] digit_offset;
  logic [35:0]        fill_value;

  modport source (
    output valid, high_word, low_word, dest_length, left_fill,
           translate_mode, digit_offset, fill_value,
    input  ready
  );

  modport sink (
    input  valid, high_word, low_word, dest_length, left_fill,
           translate_mode, digit_offset, fill_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bcd_out_if.sv
// ----------------------------------------------------------------------------
// bcd_out_if
// Result channel: fill words, digits or a field-too-short indication.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [35:0] out_value;
  logic        use_left_half;
  logic        minus_flag;
  logic        nonzero_flag;
  logic        last;

  modport source (
    output valid, kind, out_value, use_left_half, minus_flag, nonzero_flag, last,
    input  ready
  );

  modport sink (
    input  valid, kind, out_value, use_left_half, minus_flag, nonzero_flag, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bcd_front.sv
// ----------------------------------------------------------------------------
// bcd_front
// Takes a request, forms the magnitude and searches the field width, one
// power-of-ten compare per cycle, then pushes a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_front #(
  parameter int unsigned MAX_LENGTH = 63
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  bcd_in_if.sink              in_i,
  output logic                push_valid_o,
  input  wire                 push_ready_i,
  output bcd_pkg::bcd_cmd_t   push_cmd_o
);

  localparam logic [bcd_pkg::LenW-1:0] MaxLen = bcd_pkg::LenW'(MAX_LENGTH);
  localparam logic [bcd_pkg::WidthW-1:0] TopWidth =
    bcd_pkg::WidthW'(bcd_pkg::PowerEntries);

  bcd_pkg::bcd_fe_state_e state_q, state_d;

  logic [bcd_pkg::MagW-1:0]        mag_q;
  logic [bcd_pkg::WidthW-1:0]      width_q, width_d;
  logic [bcd_pkg::LenW-1:0]        len_q;
  logic                            lfill_q;
  logic                            xlat_q;
  logic signed [bcd_pkg::OffW-1:0] off_q;
  logic [bcd_pkg::WordW-1:0]       fillv_q;
  logic                            minus_q;
  logic                            nz_q;

  logic [bcd_pkg::MagW-1:0] raw_mag;
  logic                     accept;
  logic                     hit;
  logic                     too_short;

  assign accept  = in_i.valid && in_i.ready;
  assign raw_mag = {in_i.high_word, in_i.low_word[34:0]};
  assign hit     = (mag_q >= bcd_pkg::pow10(width_q)) || (width_q == 5'd1);

  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    in_i.ready = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      bcd_pkg::FE_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          width_d = TopWidth;
          state_d = bcd_pkg::FE_SEARCH;
        end
      end
      bcd_pkg::FE_SEARCH: begin
        if (hit) begin
          state_d = bcd_pkg::FE_PUSH;
        end else begin
          width_d = width_q - 5'd1;
        end
      end
      bcd_pkg::FE_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = bcd_pkg::FE_IDLE;
        end
      end
      default: state_d = bcd_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcd_pkg::FE_IDLE;
      width_q <= '0;
    end else begin
      state_q <= state_d;
      width_q <= width_d;
    end
  end

  // Capture the request; negative values become their 71-bit magnitude
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q   <= in_i.high_word[35] ? (~raw_mag + 71'd1) : raw_mag;
      len_q   <= (in_i.dest_length > MaxLen) ? MaxLen : in_i.dest_length;
      lfill_q <= in_i.left_fill;
      xlat_q  <= in_i.translate_mode;
      off_q   <= in_i.digit_offset;
      fillv_q <= in_i.fill_value;
      minus_q <= in_i.high_word[35];
      nz_q    <= (in_i.high_word != '0) || (in_i.low_word != '0);
    end
  end

  assign too_short = {1'b0, width_q} > len_q;

  always_comb begin
    push_cmd_o            = '0;
    push_cmd_o.mag        = mag_q;
    push_cmd_o.width      = width_q;
    push_cmd_o.too_short  = too_short;
    push_cmd_o.fill_cnt   = (lfill_q && !too_short) ? (len_q - {1'b0, width_q}) : '0;
    push_cmd_o.xlat       = xlat_q;
    push_cmd_o.offset     = off_q;
    push_cmd_o.fill_value = fillv_q;
    push_cmd_o.minus      = minus_q;
    push_cmd_o.nonzero    = nz_q;
  end

endmodule

`default_nettype wire

FILE: src/bcd_queue.sv
// ----------------------------------------------------------------------------
// bcd_queue
// Short command queue between the width search and the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  bcd_pkg::bcd_cmd_t  push_cmd_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output bcd_pkg::bcd_cmd_t  pop_cmd_o
);

  localparam int unsigned CntW = $clog2(bcd_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(bcd_pkg::QueueDepth);

  bcd_pkg::bcd_cmd_t entry_q [bcd_pkg::QueueDepth];

  logic [bcd_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]           count_q;
  logic                      push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bcd_back.sv
// ----------------------------------------------------------------------------
// bcd_back
// Digit engine: emits a too-short indication, or fill words and then each
// digit, developed by repeated subtraction of the power of ten for its position.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                pop_valid_i,
  output logic               pop_ready_o,
  input  bcd_pkg::bcd_cmd_t  pop_cmd_i,
  bcd_out_if.source          out_o
);

  bcd_pkg::bcd_be_state_e state_q, state_d;

  bcd_pkg::bcd_cmd_t            cmd_q;
  logic [bcd_pkg::MagW-1:0]     rem_q, rem_d;
  logic [bcd_pkg::WidthW-1:0]   pos_q, pos_d;
  logic [bcd_pkg::LenW-1:0]     fill_q, fill_d;
  logic [bcd_pkg::DigitW-1:0]   digit_q, digit_d;

  logic                         ovalid_q, ovalid_d;
  logic [1:0]                   okind_q, okind_d;
  logic [bcd_pkg::WordW-1:0]    oval_q, oval_d;
  logic                         oleft_q, oleft_d;
  logic                         ominus_q, ominus_d;
  logic                         onz_q, onz_d;
  logic                         olast_q, olast_d;

  logic                         can_emit;
  logic [bcd_pkg::MagW:0]       diff;
  logic                         ge;
  logic [bcd_pkg::WordW-1:0]    digit_out;

  // Output register is free, or its contents are taken this cycle
  assign can_emit = !ovalid_q || out_o.ready;

  assign diff = {1'b0, rem_q} - {1'b0, bcd_pkg::pow10(pos_q)};
  assign ge   = !diff[bcd_pkg::MagW];

  assign digit_out = cmd_q.xlat ? {32'd0, digit_q}
                   : ({{18{cmd_q.offset[17]}}, cmd_q.offset} + {32'd0, digit_q});

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    digit_d     = digit_q;
    pop_ready_o = 1'b0;
    ovalid_d    = ovalid_q && !out_o.ready;
    okind_d     = okind_q;
    oval_d      = oval_q;
    oleft_d     = oleft_q;
    ominus_d    = ominus_q;
    onz_d       = onz_q;
    olast_d     = olast_q;
    unique case (state_q)
      bcd_pkg::BE_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          rem_d   = pop_cmd_i.mag;
          pos_d   = pop_cmd_i.width;
          fill_d  = pop_cmd_i.fill_cnt;
          digit_d = '0;
          if (pop_cmd_i.too_short) begin
            state_d = bcd_pkg::BE_SHORT;
          end else if (pop_cmd_i.fill_cnt != '0) begin
            state_d = bcd_pkg::BE_FILL;
          end else begin
            state_d = bcd_pkg::BE_DIGIT;
          end
        end
      end
      bcd_pkg::BE_SHORT: begin
        if (can_emit) begin
          ovalid_d = 1'b1;
          okind_d  = bcd_pkg::KIND_SHORT;
          oval_d   = '0;
          oleft_d  = 1'b0;
          ominus_d = 1'b0;
          onz_d    = 1'b0;
          olast_d  = 1'b1;
          state_d  = bcd_pkg::BE_IDLE;
        end
      end
      bcd_pkg::BE_FILL: begin
        if (can_emit) begin
          ovalid_d = 1'b1;
          okind_d  = bcd_pkg::KIND_FILL;
          oval_d   = cmd_q.fill_value;
          oleft_d  = 1'b0;
          ominus_d = cmd_q.minus;
          onz_d    = cmd_q.nonzero;
          olast_d  = 1'b0;
          fill_d   = fill_q - 6'd1;
          if (fill_q == 6'd1) begin
            state_d = bcd_pkg::BE_DIGIT;
          end
        end
      end
      bcd_pkg::BE_DIGIT: begin
        if (ge && (digit_q != bcd_pkg::DigitCap)) begin
          // subtract one more power of ten
          rem_d   = diff[bcd_pkg::MagW-1:0];
          digit_d = digit_q + 4'd1;
        end else if (can_emit) begin
          ovalid_d = 1'b1;
          okind_d  = bcd_pkg::KIND_DIGIT;
          oval_d   = digit_out;
          oleft_d  = cmd_q.xlat && cmd_q.minus && (pos_q == 5'd1);
          ominus_d = cmd_q.minus;
          onz_d    = cmd_q.nonzero;
          olast_d  = (pos_q == 5'd1);
          digit_d  = '0;
          pos_d    = pos_q - 5'd1;
          if (pos_q == 5'd1) begin
            state_d = bcd_pkg::BE_IDLE;
          end
        end
      end
      default: state_d = bcd_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bcd_pkg::BE_IDLE;
      ovalid_q <= 1'b0;
      pos_q    <= '0;
      fill_q   <= '0;
      digit_q  <= '0;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      digit_q  <= digit_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcd_pkg::BE_IDLE && pop_valid_i) begin
      cmd_q <= pop_cmd_i;
    end
    okind_q  <= okind_d;
    oval_q   <= oval_d;
    oleft_q  <= oleft_d;
    ominus_q <= ominus_d;
    onz_q    <= onz_d;
    olast_q  <= olast_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.kind          = okind_q;
  assign out_o.out_value     = oval_q;
  assign out_o.use_left_half = oleft_q;
  assign out_o.minus_flag    = ominus_q;
  assign out_o.nonzero_flag  = onz_q;
  assign out_o.last          = olast_q;

endmodule

`default_nettype wire

FILE: src/binary_to_decimal_digits_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_core
// Converts a signed 71-bit double-word integer to a stream of decimal digits.
//
// in_i carries one conversion request per transfer; out_o carries its results:
// optional fill words, then the digits most significant first, or a single
// field-too-short result. The last result of each conversion has last set.
// The front forms the magnitude in the accept cycle and searches the field
// width with one power-of-ten compare per cycle, then hands a command to a
// two-entry queue. The back, which sets the throughput, takes each command,
// emits one result per fill word and then develops each digit by repeated
// subtraction of the power of ten for its position. The front searches the
// next request while the back still works on the previous one.
// A stalled receiver holds the output register and pauses the back; the queue
// then fills and the input stops accepting. Reset empties the queue and the
// output register and returns both parts to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_digits_core #(
  parameter int unsigned MAX_LENGTH = 63
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  bcd_in_if.sink    in_i,
  bcd_out_if.source out_o
);

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  bcd_pkg::bcd_cmd_t push_cmd, pop_cmd;

  bcd_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  bcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  bcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

  // A too-short indication is always the whole conversion
  a_short_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == bcd_pkg::KIND_SHORT) |-> out_o.last)
    else $error("too-short result without last");

  // Fill words always precede at least one digit
  a_fill_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == bcd_pkg::KIND_FILL) |-> !out_o.last)
    else $error("fill word marked last");

  // Left-half select only on the final digit of a negative number
  a_left_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.use_left_half |->
      out_o.last && out_o.minus_flag && (out_o.kind == bcd_pkg::KIND_DIGIT))
    else $error("left-half select on wrong result");

  // The front holds its command while the queue is full
  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid)
    else $error("front dropped a command");

endmodule

`default_nettype wire

FILE: tb/binary_to_decimal_digits_checker.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_checker
// Watches the request and result channels of the decimal digit converter.
// Every accepted request is expanded into its expected fill words, digits or
// too-short indication. Every accepted result is compared field by field
// against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_digits_checker
  import bcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bcd_in_if    in_mon,
  bcd_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bcd_kind_e        kind;
    logic [WordW-1:0] value;
    logic             left_half;
    logic             minus;
    logic             nonzero;
    logic             last;
  } digit_result_t;

  digit_result_t digits_due[$];
  int            mismatches = 0;

  function automatic logic [MagW-1:0] ten_to(input int n);
    logic [MagW-1:0] v;
    v = 1;
    for (int i = 0; i < n; i++) v = v * 71'd10;
    return v;
  endfunction

  task automatic push_result(input bcd_kind_e kind, input logic [WordW-1:0] value,
                             input logic left_half, input logic minus,
                             input logic nonzero, input logic last);
    digit_result_t r;
    r.kind      = kind;
    r.value     = value;
    r.left_half = left_half;
    r.minus     = minus;
    r.nonzero   = nonzero;
    r.last      = last;
    digits_due.push_back(r);
  endtask

  // Expand one conversion request into the results it must produce
  task automatic queue_conversion(input logic [WordW-1:0] hi, input logic [WordW-1:0] lo,
                                  input logic [LenW-1:0] len, input logic lfill,
                                  input logic xlat, input logic [OffW-1:0] off,
                                  input logic [WordW-1:0] fillv);
    logic [MagW-1:0]  mag;
    logic [MagW-1:0]  step;
    logic [WordW-1:0] off_ext;
    logic             minus;
    logic             nonzero;
    int               width;
    int               digit;
    minus   = hi[WordW-1];
    nonzero = (hi != '0) || (lo != '0);
    // low word bit 35 does not take part in the value
    mag = {hi, lo[WordW-2:0]};
    if (minus) mag = -mag;
    off_ext = {{(WordW-OffW){off[OffW-1]}}, off};

    width = 1;
    for (int k = 2; k <= PowerEntries; k++) begin
      if (mag >= ten_to(k - 1)) width = k;
    end

    if (width > int'(len)) begin
      push_result(KIND_SHORT, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    end else begin
      if (lfill) begin
        for (int i = width; i < int'(len); i++)
          push_result(KIND_FILL, fillv, 1'b0, minus, nonzero, 1'b0);
      end
      for (int p = width; p >= 1; p--) begin
        step  = ten_to(p - 1);
        digit = 0;
        while (digit < 10 && mag >= step) begin
          mag   = mag - step;
          digit = digit + 1;
        end
        push_result(KIND_DIGIT, xlat ? WordW'(digit) : WordW'(digit) + off_ext,
                    xlat && minus && (p == 1), minus, nonzero, p == 1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    digit_result_t want;
    if (rst_ni) begin
      // compare before predicting: a request never yields a result in its own cycle
      if (out_mon.valid && out_mon.ready) begin
        if (digits_due.size() == 0) begin
          $error("unexpected result: kind %0d value %0h", out_mon.kind, out_mon.out_value);
          mismatches++;
        end else begin
          want = digits_due.pop_front();
          check_field("kind", WordW'(want.kind), WordW'(out_mon.kind));
          check_field("out_value", want.value, out_mon.out_value);
          check_field("use_left_half", WordW'(want.left_half), WordW'(out_mon.use_left_half));
          check_field("minus_flag", WordW'(want.minus), WordW'(out_mon.minus_flag));
          check_field("nonzero_flag", WordW'(want.nonzero), WordW'(out_mon.nonzero_flag));
          check_field("last", WordW'(want.last), WordW'(out_mon.last));
        end
      end
      if (in_mon.valid && in_mon.ready)
        queue_conversion(in_mon.high_word, in_mon.low_word, in_mon.dest_length,
                         in_mon.left_fill, in_mon.translate_mode, in_mon.digit_offset,
                         in_mon.fill_value);
    end
    fail_count_o <= mismatches;
    pending_o    <= digits_due.size();
  end

endmodule

`default_nettype wire

FILE: tb/binary_to_decimal_digits_core_test.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_core_test
// Drives conversion requests into the decimal digit converter: a directed set
// covering zero, the most negative value, the largest values, too-short
// fields, fill and both digit modes, then random requests in phases of
// free flow, sender idling, receiver stalls, both, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_digits_core_test;
  import bcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WordW-1:0] hi;
    logic [WordW-1:0]        lo;
    logic [LenW-1:0]         len;
    logic                    lfill;
    logic                    xlat;
    logic signed [OffW-1:0]  off;
    logic [WordW-1:0]        fillv;
  } conv_req_t;

  typedef enum int {
    RUN_FREE,
    RUN_SRC_IDLE,
    RUN_SNK_STALL,
    RUN_BOTH,
    RUN_HOLDOFF
  } flow_mode_e;

  localparam int RandomPerPhase = 90;
  localparam int HoldOffCycles  = 400;
  localparam int DrainLimit     = 40000;
  localparam int TailCycles     = 300;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  int         fail_count;
  int         pending;
  flow_mode_e flow_mode = RUN_FREE;

  bcd_in_if  in_ch ();
  bcd_out_if out_ch ();

  binary_to_decimal_digits_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  binary_to_decimal_digits_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5ns clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("** binary_to_decimal_digits_core: FAILED **");
    $finish;
  end

  // Result side: random stalls per phase, one long hold-off in its phase
  initial begin
    int hold_left;
    bit hold_spent;
    hold_left  = 0;
    hold_spent = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (flow_mode == RUN_HOLDOFF && !hold_spent) begin
        hold_left  = HoldOffCycles;
        hold_spent = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (flow_mode)
          RUN_SNK_STALL: out_ch.ready <= ($urandom_range(99) >= 58);
          RUN_BOTH:      out_ch.ready <= ($urandom_range(99) >= 30);
          default:       out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic conv_req_t make_req(input logic [WordW-1:0] hi, input logic [WordW-1:0] lo,
                                         input int len, input bit lfill, input bit xlat,
                                         input logic [OffW-1:0] off,
                                         input logic [WordW-1:0] fillv);
    conv_req_t r;
    r.hi    = hi;
    r.lo    = lo;
    r.len   = LenW'(len);
    r.lfill = lfill;
    r.xlat  = xlat;
    r.off   = off;
    r.fillv = fillv;
    return r;
  endfunction

  // Mostly values of a chosen digit count with a length near it
  function automatic conv_req_t random_req();
    conv_req_t       r;
    logic [MagW-1:0] p;
    logic [MagW-1:0] mag;
    logic [MagW-1:0] val;
    logic [MagW-1:0] span;
    logic [95:0]     noise;
    int              digits;
    int              pick;
    int              n;
    bit              neg;
    digits = $urandom_range(1, PowerEntries);
    p = 1;
    for (int i = 1; i < digits; i++) p = p * 71'd10;
    noise = {$urandom, $urandom, $urandom};
    neg   = 1'($urandom_range(1));
    pick  = $urandom_range(99);
    if (pick < 20) begin
      mag = p - 1 + MagW'($urandom_range(2));
    end else begin
      span = (digits == PowerEntries) ? (71'd1 << 70) + 1 - p : p * 71'd9;
      mag  = p + MagW'(noise % 96'(span));
    end
    if (!neg && mag[MagW-1]) mag = mag - 1;
    val = neg ? -mag : mag;
    r.hi = val[MagW-1:WordW-1];
    r.lo = {1'($urandom_range(1)), val[WordW-2:0]};
    if (pick >= 85) begin
      r.hi   = {4'($urandom_range(15)), 32'($urandom)};
      r.lo   = {4'($urandom_range(15)), 32'($urandom)};
      digits = PowerEntries;
    end

    pick = $urandom_range(99);
    if (pick < 55)      n = digits + int'($urandom_range(4));
    else if (pick < 70) n = digits - 1;
    else if (pick < 85) n = int'($urandom_range(63));
    else                n = 63;
    if (n > 63) n = 63;
    if (n < 0) n = 0;
    r.len   = LenW'(n);
    r.lfill = 1'($urandom_range(1));
    r.xlat  = 1'($urandom_range(1));
    pick    = $urandom_range(99);
    if (pick < 5)       r.off = 18'h1FFFF;
    else if (pick < 10) r.off = 18'h20000;
    else                r.off = 18'($urandom);
    r.fillv = {4'($urandom_range(15)), 32'($urandom)};
    return r;
  endfunction

  // Hold valid across back-to-back requests; drop it only for idle cycles
  task automatic offer_conversion(input conv_req_t r);
    int idle_pct;
    idle_pct = (flow_mode == RUN_SRC_IDLE) ? 58 : (flow_mode == RUN_BOTH) ? 30 : 0;
    while (int'($urandom_range(99)) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.high_word      <= r.hi;
    in_ch.low_word       <= r.lo;
    in_ch.dest_length    <= r.len;
    in_ch.left_fill      <= r.lfill;
    in_ch.translate_mode <= r.xlat;
    in_ch.digit_offset   <= r.off;
    in_ch.fill_value     <= r.fillv;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  initial begin
    conv_req_t plan[$];
    in_ch.valid          = 1'b0;
    in_ch.high_word      = '0;
    in_ch.low_word       = '0;
    in_ch.dest_length    = '0;
    in_ch.left_fill      = 1'b0;
    in_ch.translate_mode = 1'b0;
    in_ch.digit_offset   = '0;
    in_ch.fill_value     = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // zero source, zero length, bit 35 of the low word alone
    plan.push_back(make_req(36'h0, 36'h0, 1, 0, 0, 18'h0, 36'h0));
    plan.push_back(make_req(36'h0, 36'h0, 0, 1, 1, 18'h0, 36'h0));
    plan.push_back(make_req(36'h0, 36'h0, 63, 1, 1, 18'h0, 36'hFFFFFFFFF));
    plan.push_back(make_req(36'h0, 36'h800000000, 3, 1, 0, 18'h30, 36'h5A5A5A5A5));
    // most negative source: magnitude 2^70
    plan.push_back(make_req(36'h800000000, 36'h0, 22, 1, 1, 18'h0, 36'h0));
    plan.push_back(make_req(36'h800000000, 36'h0, 21, 1, 1, 18'h0, 36'h0));
    plan.push_back(make_req(36'h800000000, 36'h0, 63, 1, 0, 18'h20000, 36'hA5A5A5A5A));
    // largest positive source
    plan.push_back(make_req(36'h7FFFFFFFF, 36'hFFFFFFFFF, 63, 1, 0, 18'h1FFFF, 36'h0));
    plan.push_back(make_req(36'h7FFFFFFFF, 36'h7FFFFFFFF, 63, 0, 1, 18'h0, 36'h0));
    // minus one: left half on the last digit in translate mode
    plan.push_back(make_req(36'hFFFFFFFFF, 36'h7FFFFFFFF, 5, 1, 1, 18'h0, 36'h123456789));
    plan.push_back(make_req(36'hFFFFFFFFF, 36'h7FFFFFFFF, 0, 0, 0, 18'h0, 36'h0));
    // field width exactly fitting and one digit over
    plan.push_back(make_req(36'h0, 36'd9999999999, 10, 1, 0, 18'h30, 36'h0));
    plan.push_back(make_req(36'h0, 36'd10000000000, 10, 1, 0, 18'h30, 36'h0));
    plan.push_back(make_req(36'hFFFFFFFFF, 36'd24359738368, 11, 0, 1, 18'h0, 36'h0));
    plan.push_back(make_req(36'h1, 36'h0, 20, 1, 0, 18'h3FFFF, 36'h800000001));
    plan.push_back(make_req(36'h0, 36'h0, 63, 0, 0, 18'h20000, 36'h0));
    foreach (plan[i]) offer_conversion(plan[i]);
    in_ch.valid <= 1'b0;
    drain_results(DrainLimit);

    for (int ph = 0; ph <= RUN_HOLDOFF; ph++) begin
      flow_mode <= flow_mode_e'(ph);
      repeat (RandomPerPhase) offer_conversion(random_req());
      // pause the sender until every outstanding result is out
      in_ch.valid <= 1'b0;
      drain_results(DrainLimit);
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending != 0)
      $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** binary_to_decimal_digits_core: PASSED **");
    end else begin
      $display("** binary_to_decimal_digits_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
